// ----- rtl/core/cdt_pkg.sv -----
package cdt_pkg;

   typedef enum logic [1:0] {
      MODE_SETUP   = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_PAUSED  = 2'd2,
      MODE_EXPIRED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ADJUST = 3'd0,
      KIND_START  = 3'd1,
      KIND_PAUSE  = 3'd2,
      KIND_RESUME = 3'd3,
      KIND_STOP   = 3'd4,
      KIND_TICK   = 3'd5,
      KIND_ACK    = 3'd6
   } kind_type;

   localparam int unsigned SECS_W = 19;
   localparam int unsigned TM_W   = 13;   // whole minutes, up to 5999
   localparam int unsigned TPS_W  = 16;

   localparam logic [SECS_W-1:0] DURATION_MAX   = 19'd359999;
   localparam logic [SECS_W-1:0] DURATION_RESET = 19'd1500;
   localparam logic [TPS_W-1:0]  TPS_RESET      = 16'd1000;

   // floor(x / 60) as (x * M) >> S, exact over the stated input range
   localparam int unsigned DIV60_SECS_S = 25;
   localparam logic [19:0] DIV60_SECS_M = 20'd559241;
   localparam int unsigned DIV60_MINS_S = 19;
   localparam logic [13:0] DIV60_MINS_M = 14'd8739;

   typedef struct packed {
      mode_type          mode;
      logic [SECS_W-1:0] duration;
      logic [SECS_W-1:0] remaining;
      logic [SECS_W-1:0] shown;
   } snap_type;

endpackage

// ----- rtl/core/countdown_timer_with_pause.sv -----
// Countdown timer with setup, running, paused and expired modes.
// req channel: one event beat (req_kind, req_delta_seconds) per accept,
// taken on a rising edge with req_valid high and req_stall low.
// rsp channel: exactly one result beat per event, in order, carrying the
// mode, duration, remaining seconds and an HH:MM:SS split of the value on
// screen (duration in setup, remaining otherwise).
// csr_we/csr_wdata write ticks_per_second; write only while idle.
// A beat passes five registers from the accepting edge to rsp_valid: input
// register, state update, divide by 60 of the shown value, divide by 60 of
// the minutes, result register. One beat per cycle is sustained while
// rsp_stall is low.
// Each stage moves whenever the stage after it is empty or moving, so a
// stalled result lets up to four further beats enter behind it; req_stall
// rises only once every stage is full.
// Reset (synchronous, active high) empties the pipeline and returns the
// timer to setup with a 1500 s duration and 1000 ticks per second.
module countdown_timer_with_pause
   import cdt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_kind,
   input  logic signed [15:0]       req_delta_seconds,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_mode,
   output logic [SECS_W-1:0]        rsp_duration_seconds,
   output logic [SECS_W-1:0]        rsp_remaining_seconds,
   output logic [6:0]               rsp_shown_hours,
   output logic [5:0]               rsp_shown_minutes,
   output logic [5:0]               rsp_shown_secs,
   input  logic                     csr_we,
   input  logic [TPS_W-1:0]         csr_wdata
);

   // pipeline valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage payloads
   logic [2:0]          kind1_ff;
   logic signed [15:0]  delta1_ff;
   snap_type            snap2_ff, snap3_ff;
   snap_type            snap4_ff, snap5_ff;
   logic [TM_W-1:0]     tm3_ff, tm4_ff;
   logic [5:0]          secs4_ff, secs5_ff;
   logic [6:0]          hours4_ff, hours5_ff;
   logic [5:0]          mins5_ff;

   // timer state
   mode_type            mode_ff, mode_in;
   logic [SECS_W-1:0]   duration_ff, duration_in;
   logic [SECS_W-1:0]   remaining_ff, remaining_in;
   logic [TPS_W-1:0]    subsec_ff, subsec_in;
   logic [TPS_W-1:0]    tps_ff;

   logic                load2;
   logic signed [20:0]  adj_sum;
   logic [TPS_W-1:0]    sub_inc;
   logic [SECS_W-1:0]   rem_dec;
   logic [SECS_W-1:0]   shown_in;

   logic [38:0]         prod_secs;
   logic [26:0]         prod_mins;
   logic [SECS_W-1:0]   secs_full;
   logic [TM_W-1:0]     mins_full;

   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;
   assign load2 = v1_ff && rdy2;

   // event decode and state update
   always_comb begin
      mode_in      = mode_ff;
      duration_in  = duration_ff;
      remaining_in = remaining_ff;
      subsec_in    = subsec_ff;
      adj_sum      = signed'({2'b00, duration_ff}) + 21'(delta1_ff);
      sub_inc      = subsec_ff + 16'd1;
      rem_dec      = (remaining_ff != '0) ? remaining_ff - 19'd1 : remaining_ff;
      if (load2) begin
         case (kind1_ff)
            KIND_ADJUST: begin
               if (mode_ff == MODE_SETUP) begin
                  if (adj_sum < 21'sd1)
                     duration_in = 19'd1;
                  else if (adj_sum > 21'sd359999)
                     duration_in = DURATION_MAX;
                  else
                     duration_in = adj_sum[SECS_W-1:0];
               end
            end
            KIND_START: begin
               remaining_in = duration_ff;
               subsec_in    = '0;
               mode_in      = MODE_RUNNING;
            end
            KIND_PAUSE: begin
               if (mode_ff == MODE_RUNNING) mode_in = MODE_PAUSED;
            end
            KIND_RESUME: begin
               if (mode_ff == MODE_PAUSED) begin
                  subsec_in = '0;
                  mode_in   = MODE_RUNNING;
               end
            end
            KIND_STOP: begin
               remaining_in = '0;
               mode_in      = MODE_SETUP;
            end
            KIND_TICK: begin
               if (mode_ff == MODE_RUNNING) begin
                  if (sub_inc >= tps_ff) begin
                     subsec_in    = '0;
                     remaining_in = rem_dec;
                     if (rem_dec == '0) mode_in = MODE_EXPIRED;
                  end else begin
                     subsec_in = sub_inc;
                  end
               end
            end
            KIND_ACK: begin
               if (mode_ff == MODE_EXPIRED) mode_in = MODE_SETUP;
            end
            default: begin
            end
         endcase
      end
      shown_in = (mode_in == MODE_SETUP) ? duration_in : remaining_in;
   end

   // H:M:S split
   assign prod_secs = 39'(snap2_ff.shown) * 39'(DIV60_SECS_M);
   assign secs_full = snap3_ff.shown - (19'(tm3_ff) * 19'd60);
   assign prod_mins = 27'(tm3_ff) * 27'(DIV60_MINS_M);
   assign mins_full = tm4_ff - (13'(hours4_ff) * 13'd60);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         mode_ff      <= MODE_SETUP;
         duration_ff  <= DURATION_RESET;
         remaining_ff <= '0;
         subsec_ff    <= '0;
         tps_ff       <= TPS_RESET;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         mode_ff      <= mode_in;
         duration_ff  <= duration_in;
         remaining_ff <= remaining_in;
         subsec_ff    <= subsec_in;
         if (csr_we) tps_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         kind1_ff  <= req_kind;
         delta1_ff <= req_delta_seconds;
      end
      if (rdy2) begin
         snap2_ff <= '{mode: mode_in, duration: duration_in,
                       remaining: remaining_in, shown: shown_in};
      end
      if (rdy3) begin
         snap3_ff <= snap2_ff;
         tm3_ff   <= prod_secs[DIV60_SECS_S +: TM_W];
      end
      if (rdy4) begin
         snap4_ff  <= snap3_ff;
         tm4_ff    <= tm3_ff;
         secs4_ff  <= secs_full[5:0];
         hours4_ff <= prod_mins[DIV60_MINS_S +: 7];
      end
      if (rdy5) begin
         snap5_ff  <= snap4_ff;
         secs5_ff  <= secs4_ff;
         hours5_ff <= hours4_ff;
         mins5_ff  <= mins_full[5:0];
      end
   end

   assign rsp_valid             = v5_ff;
   assign rsp_mode              = snap5_ff.mode;
   assign rsp_duration_seconds  = snap5_ff.duration;
   assign rsp_remaining_seconds = snap5_ff.remaining;
   assign rsp_shown_hours       = hours5_ff;
   assign rsp_shown_minutes     = mins5_ff;
   assign rsp_shown_secs        = secs5_ff;

endmodule

// ----- rtl/core/cdt_checker.sv -----
module cdt_checker
   import cdt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [1:0]          rsp_mode,
   input  logic [SECS_W-1:0]   rsp_duration_seconds,
   input  logic [SECS_W-1:0]   rsp_remaining_seconds,
   input  logic [6:0]          rsp_shown_hours,
   input  logic [5:0]          rsp_shown_minutes,
   input  logic [5:0]          rsp_shown_secs
);

   a_split_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shown_hours <= 7'd99) && (rsp_shown_minutes < 6'd60)
                    && (rsp_shown_secs < 6'd60))
      else $error("H:M:S split out of range");

   a_duration_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duration_seconds != '0)
                    && (rsp_duration_seconds <= DURATION_MAX))
      else $error("duration outside clamp range");

   a_expired_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == MODE_EXPIRED) |-> rsp_remaining_seconds == '0)
      else $error("expired with seconds left");

   a_counting_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_mode == MODE_RUNNING || rsp_mode == MODE_PAUSED))
         |-> rsp_remaining_seconds != '0)
      else $error("running or paused at zero");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_remaining_seconds) && $stable(rsp_shown_secs))
      else $error("stalled beat changed");

endmodule

bind countdown_timer_with_pause cdt_checker u_cdt_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_mode              (rsp_mode),
   .rsp_duration_seconds  (rsp_duration_seconds),
   .rsp_remaining_seconds (rsp_remaining_seconds),
   .rsp_shown_hours       (rsp_shown_hours),
   .rsp_shown_minutes     (rsp_shown_minutes),
   .rsp_shown_secs        (rsp_shown_secs)
);
